// ----- hw/rtl/pmfg_pkg.sv -----
// Shared types, constants and tables for the prism face generator.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package pmfg_pkg;

	localparam int MAX_SIDES_DEF   = 256;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int VERTS           = 12;
	localparam int PHASE_W         = 32;
	localparam int TRIG_W          = 33;
	localparam int DIV_BITS        = 4;
	localparam int DIV_STAGES      = PHASE_W / DIV_BITS;
	localparam int CORDIC_STEPS    = 16;
	localparam int CORDIC_PER      = 2;
	localparam int CORDIC_STAGES   = CORDIC_STEPS / CORDIC_PER;
	localparam int FIFO_DEPTH      = 4;

	localparam logic [14:0] RADIUS_RST = 15'd4096;
	localparam logic [14:0] HALF_RST   = 15'd2048;
	localparam logic [8:0]  NUM_DIV_RST = 9'd24;
	localparam logic [31:0] RGBA_RST   = 32'hFFFF_FFFF;

	localparam logic signed [TRIG_W-1:0] CORDIC_START = 33'sd652032874;
	localparam logic signed [TRIG_W-1:0] ONE_Q30      = 33'sd1073741824;

	typedef enum logic [1:0] {
		REG_RADIUS      = 2'd0,
		REG_HALF_LENGTH = 2'd1,
		REG_NUM_DIV     = 2'd2,
		REG_RGBA        = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		RING_A      = 2'd0,
		RING_B      = 2'd1,
		RING_CENTER = 2'd2
	} ring_sel_t;

	typedef struct packed {
		logic       second;
		logic [7:0] face;
	} job_tag_t;

	localparam logic [29:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861
	};

	localparam ring_sel_t SLOT_RING [0:VERTS-1] = '{
		RING_A, RING_B, RING_A, RING_A, RING_B, RING_B,
		RING_A, RING_CENTER, RING_B, RING_CENTER, RING_A, RING_B
	};

	localparam logic SLOT_TOP [0:VERTS-1] = '{
		1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0
	};

	function automatic logic signed [TRIG_W-1:0] shr_tz(
		input logic signed [TRIG_W-1:0] v,
		input int                       sh
	);
		logic signed [TRIG_W-1:0] m;
		begin
			if (v < 0) begin
				m = -v;
				shr_tz = -(m >>> sh);
			end else begin
				shr_tz = v >>> sh;
			end
		end
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pmfg_phase_div.sv -----
// Pipelined restoring divider that turns ring vertex k of n into a 32-bit
// phase, rounded to nearest. Depends on pmfg_pkg.
`default_nettype none

module pmfg_phase_div
	import pmfg_pkg::*;
#(
	parameter int NW = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [NW-1:0]      in_k,
	input  logic [NW-1:0]      in_n,
	input  job_tag_t           in_tag,
	output logic               out_valid,
	output logic [PHASE_W-1:0] out_phase,
	output job_tag_t           out_tag
);

	logic               vld_s [0:DIV_STAGES];
	logic [NW-1:0]      rem_s [0:DIV_STAGES];
	logic [NW-1:0]      den_s [0:DIV_STAGES];
	logic [PHASE_W-1:0] quo_s [0:DIV_STAGES];
	logic [PHASE_W-1:0] low_s [0:DIV_STAGES];
	job_tag_t           tag_s [0:DIV_STAGES];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = in_k;
	assign den_s[0] = in_n;
	assign quo_s[0] = '0;
	assign low_s[0] = PHASE_W'(in_n >> 1);
	assign tag_s[0] = in_tag;

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
		logic [NW-1:0]      r_c;
		logic [NW:0]        t_c;
		logic [PHASE_W-1:0] q_c;
		logic [PHASE_W-1:0] l_c;

		always_comb begin
			r_c = rem_s[s];
			q_c = quo_s[s];
			l_c = low_s[s];
			t_c = '0;
			for (int b = 0; b < DIV_BITS; b++) begin
				t_c = {r_c, l_c[PHASE_W-1]};
				l_c = {l_c[PHASE_W-2:0], 1'b0};
				if (t_c >= {1'b0, den_s[s]}) begin
					r_c = NW'(t_c - {1'b0, den_s[s]});
					q_c = {q_c[PHASE_W-2:0], 1'b1};
				end else begin
					r_c = t_c[NW-1:0];
					q_c = {q_c[PHASE_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s+1] <= 1'b0;
			end else begin
				vld_s[s+1] <= vld_s[s];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[s+1] <= r_c;
			den_s[s+1] <= den_s[s];
			quo_s[s+1] <= q_c;
			low_s[s+1] <= l_c;
			tag_s[s+1] <= tag_s[s];
		end
	end

	assign out_valid = vld_s[DIV_STAGES];
	assign out_phase = quo_s[DIV_STAGES];
	assign out_tag   = tag_s[DIV_STAGES];

endmodule

`default_nettype wire

// ----- hw/rtl/pmfg_cordic.sv -----
// Pipelined rotation-mode CORDIC giving cos and sin in Q2.30 of a phase in
// turns, two iterations per stage, with quadrant fold. Depends on pmfg_pkg.
`default_nettype none

module pmfg_cordic
	import pmfg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [PHASE_W-1:0]       in_phase,
	input  job_tag_t                 in_tag,
	output logic                     out_valid,
	output logic signed [TRIG_W-1:0] out_cos,
	output logic signed [TRIG_W-1:0] out_sin,
	output job_tag_t                 out_tag
);

	logic                     vld_s  [0:CORDIC_STAGES];
	logic signed [TRIG_W-1:0] x_s    [0:CORDIC_STAGES];
	logic signed [TRIG_W-1:0] y_s    [0:CORDIC_STAGES];
	logic signed [31:0]       z_s    [0:CORDIC_STAGES];
	logic [1:0]               quad_s [0:CORDIC_STAGES];
	logic                     zero_s [0:CORDIC_STAGES];
	job_tag_t                 tag_s  [0:CORDIC_STAGES];

	assign vld_s[0]  = in_valid;
	assign x_s[0]    = CORDIC_START;
	assign y_s[0]    = '0;
	assign z_s[0]    = signed'({2'b00, in_phase[29:0]});
	assign quad_s[0] = in_phase[31:30];
	assign zero_s[0] = (in_phase[29:0] == '0);
	assign tag_s[0]  = in_tag;

	for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
		logic signed [TRIG_W-1:0] x_c;
		logic signed [TRIG_W-1:0] y_c;
		logic signed [TRIG_W-1:0] dx;
		logic signed [TRIG_W-1:0] dy;
		logic signed [31:0]       z_c;

		always_comb begin
			x_c = x_s[s];
			y_c = y_s[s];
			z_c = z_s[s];
			dx  = '0;
			dy  = '0;
			for (int b = 0; b < CORDIC_PER; b++) begin
				dx = shr_tz(y_c, s * CORDIC_PER + b);
				dy = shr_tz(x_c, s * CORDIC_PER + b);
				if (z_c >= 0) begin
					x_c = x_c - dx;
					y_c = y_c + dy;
					z_c = z_c - signed'({2'b00, ATAN_TURNS[s * CORDIC_PER + b]});
				end else begin
					x_c = x_c + dx;
					y_c = y_c - dy;
					z_c = z_c + signed'({2'b00, ATAN_TURNS[s * CORDIC_PER + b]});
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s+1] <= 1'b0;
			end else begin
				vld_s[s+1] <= vld_s[s];
			end
		end

		always_ff @(posedge clk) begin
			x_s[s+1]    <= x_c;
			y_s[s+1]    <= y_c;
			z_s[s+1]    <= z_c;
			quad_s[s+1] <= quad_s[s];
			zero_s[s+1] <= zero_s[s];
			tag_s[s+1]  <= tag_s[s];
		end
	end

	logic signed [TRIG_W-1:0] bx;
	logic signed [TRIG_W-1:0] by;
	logic signed [TRIG_W-1:0] c_c;
	logic signed [TRIG_W-1:0] s_c;

	always_comb begin
		bx = zero_s[CORDIC_STAGES] ? ONE_Q30 : x_s[CORDIC_STAGES];
		by = zero_s[CORDIC_STAGES] ? '0 : y_s[CORDIC_STAGES];
		case (quad_s[CORDIC_STAGES])
			2'd0: begin
				c_c = bx;
				s_c = by;
			end
			2'd1: begin
				c_c = -by;
				s_c = bx;
			end
			2'd2: begin
				c_c = -bx;
				s_c = -by;
			end
			default: begin
				c_c = by;
				s_c = -bx;
			end
		endcase
	end

	logic     vld_q;
	job_tag_t tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_s[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		out_cos <= c_c;
		out_sin <= s_c;
		tag_q   <= tag_s[CORDIC_STAGES];
	end

	assign out_valid = vld_q;
	assign out_tag   = tag_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pmfg_scale.sv -----
// Scales Q2.30 cos and sin by the radius with rounding and saturation to
// the coordinate width, in three stages. Depends on pmfg_pkg.
`default_nettype none

module pmfg_scale
	import pmfg_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [TRIG_W-1:0]      in_cos,
	input  logic signed [TRIG_W-1:0]      in_sin,
	input  job_tag_t                      in_tag,
	input  logic [14:0]                   radius,
	output logic                          out_valid,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_z,
	output job_tag_t                      out_tag
);

	localparam int SW = (COORD_WIDTH > 18 ? COORD_WIDTH : 18) + 1;
	localparam logic signed [SW-1:0] LIM_HI = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
	localparam logic signed [SW-1:0] LIM_LO = -LIM_HI - SW'(1);

	logic        vld_s1, vld_s2, vld_s3;
	logic [31:0] mx_s1, mz_s1;
	logic        nx_s1, nz_s1, nx_s2, nz_s2;
	logic [46:0] px_s2, pz_s2;
	job_tag_t    tag_s1, tag_s2, tag_s3;
	logic signed [COORD_WIDTH-1:0] x_s3, z_s3;

	function automatic logic signed [COORD_WIDTH-1:0] round_sat(
		input logic [46:0] p,
		input logic        neg
	);
		logic [16:0]        r;
		logic signed [SW-1:0] v;
		begin
			r = 17'((p + 47'(1 << 29)) >> 30);
			v = neg ? -SW'(r) : SW'(r);
			if (v > LIM_HI) begin
				v = LIM_HI;
			end else if (v < LIM_LO) begin
				v = LIM_LO;
			end
			round_sat = v[COORD_WIDTH-1:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		nx_s1  <= in_cos < 0;
		nz_s1  <= in_sin < 0;
		mx_s1  <= 32'(in_cos < 0 ? -in_cos : in_cos);
		mz_s1  <= 32'(in_sin < 0 ? -in_sin : in_sin);
		tag_s1 <= in_tag;
		px_s2  <= 47'(mx_s1) * 47'(radius);
		pz_s2  <= 47'(mz_s1) * 47'(radius);
		nx_s2  <= nx_s1;
		nz_s2  <= nz_s1;
		tag_s2 <= tag_s1;
		x_s3   <= round_sat(px_s2, nx_s2);
		z_s3   <= round_sat(pz_s2, nz_s2);
		tag_s3 <= tag_s2;
	end

	assign out_valid = vld_s3;
	assign out_x     = x_s3;
	assign out_z     = z_s3;
	assign out_tag   = tag_s3;

endmodule

`default_nettype wire

// ----- hw/rtl/prism_mesh_face_generator.sv -----
// Top level of the prism face generator: configuration, job issue, result
// queue and vertex serializer. Depends on pmfg_pkg, pmfg_phase_div,
// pmfg_cordic and pmfg_scale.
//
// Channel   Direction  Handshake            Payload
// face      in         in_valid/in_ready    face
// vertex    out        out_valid/out_ready  vertex_number, pos_x/y/z, color_out, last
// config    in         cfg_we               cfg_index, cfg_data
//
// Each face sends two ring vertices through the divider, CORDIC and
// multiplier pipelines, and its vertices are output once its second ring
// vertex has left them and been queued. Output runs one vertex per cycle
// while out_ready is high; a face has 12 vertices. No request is taken in
// the cycle after one is accepted, since its second ring vertex is issued
// in that cycle. Up to four faces are in flight or queued, and the output
// port limits the sustained face rate. Reset clears all control.
// Output stalls back up only into the queue; the pipeline never stops.
`default_nettype none

module prism_mesh_face_generator
	import pmfg_pkg::*;
#(
	parameter int MAX_SIDES   = MAX_SIDES_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    face,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [11:0]                   vertex_number,
	output logic signed [COORD_WIDTH-1:0] pos_x,
	output logic signed [COORD_WIDTH-1:0] pos_y,
	output logic signed [COORD_WIDTH-1:0] pos_z,
	output logic [31:0]                   color_out,
	output logic                          last
);

	localparam int NMAX = MAX_SIDES < 511 ? MAX_SIDES : 511;
	localparam int NW   = $clog2(NMAX + 1);
	localparam int PW   = $clog2(FIFO_DEPTH);
	localparam int YW   = COORD_WIDTH > 17 ? COORD_WIDTH : 17;

	logic [14:0] radius_q, half_q;
	logic [8:0]  num_div_q;
	logic [31:0] rgba_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RADIUS_RST;
			half_q    <= HALF_RST;
			num_div_q <= NUM_DIV_RST;
			rgba_q    <= RGBA_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RADIUS:      radius_q  <= cfg_data[14:0];
				REG_HALF_LENGTH: half_q    <= cfg_data[14:0];
				REG_NUM_DIV:     num_div_q <= cfg_data[8:0];
				REG_RGBA:        rgba_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [NW-1:0] n_eff, k0, k1;
	logic [7:0]    face_c;

	always_comb begin
		if (num_div_q < 9'd3) begin
			n_eff = NW'(3);
		end else if (int'(num_div_q) > MAX_SIDES) begin
			n_eff = NW'(MAX_SIDES);
		end else begin
			n_eff = NW'(num_div_q);
		end
		if (int'(face) >= int'(n_eff)) begin
			face_c = 8'(int'(n_eff) - 1);
		end else begin
			face_c = face;
		end
		k0 = NW'(face_c);
		k1 = (int'(face_c) + 1 == int'(n_eff)) ? '0 : NW'(int'(face_c) + 1);
	end

	logic          pend_q;
	logic [7:0]    pend_face_q;
	logic [NW-1:0] pend_k_q;
	logic [PW:0]   cnt_q;
	logic          in_acc, pop;

	assign in_ready = !pend_q && (int'(cnt_q) < FIFO_DEPTH);
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			pend_q <= in_acc;
			cnt_q  <= cnt_q + (PW+1)'(in_acc) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pend_face_q <= face_c;
			pend_k_q    <= k1;
		end
	end

	logic          job_valid;
	logic [NW-1:0] job_k;
	job_tag_t      job_tag;

	assign job_valid = in_acc || pend_q;
	assign job_k     = pend_q ? pend_k_q : k0;
	assign job_tag   = pend_q ? '{second: 1'b1, face: pend_face_q}
	                          : '{second: 1'b0, face: face_c};

	logic               dv_valid;
	logic [PHASE_W-1:0] dv_phase;
	job_tag_t           dv_tag;

	pmfg_phase_div #(.NW(NW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (job_valid),
		.in_k      (job_k),
		.in_n      (n_eff),
		.in_tag    (job_tag),
		.out_valid (dv_valid),
		.out_phase (dv_phase),
		.out_tag   (dv_tag)
	);

	logic                     cr_valid;
	logic signed [TRIG_W-1:0] cr_cos, cr_sin;
	job_tag_t                 cr_tag;

	pmfg_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid),
		.in_phase  (dv_phase),
		.in_tag    (dv_tag),
		.out_valid (cr_valid),
		.out_cos   (cr_cos),
		.out_sin   (cr_sin),
		.out_tag   (cr_tag)
	);

	logic                          sc_valid;
	logic signed [COORD_WIDTH-1:0] sc_x, sc_z;
	job_tag_t                      sc_tag;

	pmfg_scale #(.COORD_WIDTH(COORD_WIDTH)) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cr_valid),
		.in_cos    (cr_cos),
		.in_sin    (cr_sin),
		.in_tag    (cr_tag),
		.radius    (radius_q),
		.out_valid (sc_valid),
		.out_x     (sc_x),
		.out_z     (sc_z),
		.out_tag   (sc_tag)
	);

	logic signed [COORD_WIDTH-1:0] x0_q, z0_q;
	logic [7:0]                    rec_face_q [0:FIFO_DEPTH-1];
	logic signed [COORD_WIDTH-1:0] rec_x0_q   [0:FIFO_DEPTH-1];
	logic signed [COORD_WIDTH-1:0] rec_z0_q   [0:FIFO_DEPTH-1];
	logic signed [COORD_WIDTH-1:0] rec_x1_q   [0:FIFO_DEPTH-1];
	logic signed [COORD_WIDTH-1:0] rec_z1_q   [0:FIFO_DEPTH-1];
	logic [PW:0]                   wptr_q, rptr_q;
	logic [3:0]                    slot_q;
	logic                          push;

	assign push = sc_valid && sc_tag.second;
	assign pop  = out_valid && out_ready && (slot_q == 4'(VERTS - 1));

	always_ff @(posedge clk) begin
		if (sc_valid && !sc_tag.second) begin
			x0_q <= sc_x;
			z0_q <= sc_z;
		end
		if (push) begin
			rec_face_q[wptr_q[PW-1:0]] <= sc_tag.face;
			rec_x0_q[wptr_q[PW-1:0]]   <= x0_q;
			rec_z0_q[wptr_q[PW-1:0]]   <= z0_q;
			rec_x1_q[wptr_q[PW-1:0]]   <= sc_x;
			rec_z1_q[wptr_q[PW-1:0]]   <= sc_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			slot_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (out_valid && out_ready) begin
				if (pop) begin
					slot_q <= '0;
					rptr_q <= rptr_q + 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	logic [PW-1:0]   head;
	logic [7:0]      hface;
	ring_sel_t       ring;
	logic signed [YW-1:0] y_w;

	assign head      = rptr_q[PW-1:0];
	assign hface     = rec_face_q[head];
	assign out_valid = (wptr_q != rptr_q);
	assign color_out = rgba_q;
	assign last      = (slot_q == 4'(VERTS - 1));
	assign vertex_number = 12'({hface, 3'b000}) + 12'({hface, 2'b00}) + 12'(slot_q);

	always_comb begin
		ring = (int'(slot_q) < VERTS) ? SLOT_RING[slot_q] : RING_CENTER;
		if ((int'(slot_q) < VERTS) && SLOT_TOP[slot_q]) begin
			y_w = YW'(signed'({1'b0, half_q}));
		end else begin
			y_w = -YW'(signed'({1'b0, half_q}));
		end
		case (ring)
			RING_A: begin
				pos_x = rec_x0_q[head];
				pos_z = rec_z0_q[head];
			end
			RING_B: begin
				pos_x = rec_x1_q[head];
				pos_z = rec_z1_q[head];
			end
			default: begin
				pos_x = '0;
				pos_z = '0;
			end
		endcase
	end

	assign pos_y = y_w[COORD_WIDTH-1:0];

	a_out_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cnt_q != '0))
		else $error("queued face without an outstanding request");

	a_job_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(sc_valid && sc_tag.second) |-> $past(sc_valid && !sc_tag.second))
		else $error("second ring vertex arrived without the first");

	a_issue_second: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (pend_q && !in_ready))
		else $error("second ring job not issued after request");

endmodule

`default_nettype wire
